// ===== design/gbpd_pkg.sv =====
// ----------------------------------------------------------------------------
// gbpd_pkg
// Shared types, mode codes and palettes for the graphics byte pixel decoder.
// ----------------------------------------------------------------------------
package gbpd_pkg;

  localparam int CellsPerByte = 7;

  // graphics_mode codes
  localparam logic [1:0] MODE_LORES  = 2'd0;
  localparam logic [1:0] MODE_HIRES  = 2'd1;
  localparam logic [1:0] MODE_DHIRES = 2'd2;
  localparam logic [1:0] MODE_RESET  = MODE_HIRES;

  localparam logic [2:0] CELL_W_NARROW = 3'd2;
  localparam logic [2:0] CELL_W_WIDE   = 3'd4;

  localparam logic [23:0] COLOR_BLACK  = 24'h000000;
  localparam logic [23:0] COLOR_WHITE  = 24'hFFFFFF;
  localparam logic [23:0] COLOR_GREEN  = 24'h20C000;
  localparam logic [23:0] COLOR_PURPLE = 24'hC000FF;
  localparam logic [23:0] COLOR_ORANGE = 24'hF06000;
  localparam logic [23:0] COLOR_BLUE   = 24'h2020FF;

  typedef struct packed {
    logic [7:0] main_byte;
    logic [7:0] aux_byte;
    logic       next_low_bit;
    logic [5:0] column;
    logic [7:0] line;
  } in_item_t;

  typedef struct packed {
    logic [23:0] color_rgb;
    logic [2:0]  cell_width;
    logic        last_of_column;
  } out_item_t;

  // line state carried from column to column
  typedef struct packed {
    logic       prev_dot;
    logic [2:0] queue;      // leftover double high-res bits, oldest in bit 0
    logic [1:0] queue_cnt;
  } line_state_t;

  typedef struct packed {
    logic [CellsPerByte-1:0][23:0] colors;
    logic [2:0]                    count;
    logic [2:0]                    width;
  } cell_run_t;

  function automatic logic [23:0] lores_color(input logic [3:0] nib);
    logic [23:0] c;
    case (nib)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'h9D09AA;
      4'd2:    c = 24'h2B2BE3;
      4'd3:    c = 24'hDB42FF;
      4'd4:    c = 24'h119D00;
      4'd5:    c = 24'h808080;
      4'd6:    c = 24'h0EA1FF;
      4'd7:    c = 24'hAAAAFF;
      4'd8:    c = 24'h885500;
      4'd9:    c = 24'hFF6600;
      4'd10:   c = 24'hAAAAAA;
      4'd11:   c = 24'hFF99FF;
      4'd12:   c = 24'h22FF00;
      4'd13:   c = 24'hFFFF00;
      4'd14:   c = 24'h44FF99;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

  function automatic logic [23:0] dhires_color(input logic [3:0] nib);
    logic [23:0] c;
    case (nib)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'hDD0033;
      4'd2:    c = 24'h000099;
      4'd3:    c = 24'hDD22DD;
      4'd4:    c = 24'h007722;
      4'd5:    c = 24'h555555;
      4'd6:    c = 24'h2222FF;
      4'd7:    c = 24'h66AAFF;
      4'd8:    c = 24'h885500;
      4'd9:    c = 24'hFF6600;
      4'd10:   c = 24'hAAAAAA;
      4'd11:   c = 24'hFF99AA;
      4'd12:   c = 24'h00DD00;
      4'd13:   c = 24'hFFFF00;
      4'd14:   c = 24'h44FF99;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

endpackage

// ===== design/gbpd_decode.sv =====
// ----------------------------------------------------------------------------
// gbpd_decode
// Decodes one column item into its run of cell colors and the next line state.
// ----------------------------------------------------------------------------
module gbpd_decode
  import gbpd_pkg::*;
(
  input  in_item_t    item,
  input  logic [1:0]  mode,
  input  line_state_t state,
  output cell_run_t   run,
  output line_state_t state_next
);

  line_state_t st;          // state after the line-start clear
  logic [3:0]  lo_nib;
  logic [23:0] lo_color;
  logic [CellsPerByte-1:0] dot_prev;
  logic [CellsPerByte-1:0] dot_next;
  logic [13:0] packed_bits;
  logic [16:0] q;
  logic [4:0]  total;
  logic        four_cells;

  always_comb begin
    st = state;
    if (item.column == 6'd0) begin
      st = '0;
    end
  end

  assign lo_nib   = item.line[2] ? item.main_byte[7:4] : item.main_byte[3:0];
  assign lo_color = lores_color(lo_nib);

  // neighbor dots for high-res
  always_comb begin
    for (int i = 0; i < CellsPerByte; i++) begin
      dot_prev[i] = (i == 0) ? st.prev_dot : item.main_byte[(i + 7) % 8];
      dot_next[i] = (i == CellsPerByte - 1) ? item.next_low_bit : item.main_byte[(i + 1) % 8];
    end
  end

  assign packed_bits = {item.main_byte[6:0], item.aux_byte[6:0]};
  assign q           = {3'b000, packed_bits} << st.queue_cnt | {14'd0, st.queue};
  assign total       = 5'd14 + {3'b000, st.queue_cnt};
  assign four_cells  = total[4];   // 16 or 17 bits queued

  always_comb begin
    run        = '0;
    state_next = st;
    case (mode)
      MODE_LORES: begin
        run.count = 3'(CellsPerByte);
        run.width = CELL_W_NARROW;
        for (int i = 0; i < CellsPerByte; i++) begin
          run.colors[i] = lo_color;
        end
      end
      MODE_HIRES: begin
        run.count = 3'(CellsPerByte);
        run.width = CELL_W_NARROW;
        for (int i = 0; i < CellsPerByte; i++) begin
          if (!item.main_byte[i]) begin
            run.colors[i] = COLOR_BLACK;
          end else if (dot_prev[i] || dot_next[i]) begin
            run.colors[i] = COLOR_WHITE;
          end else if (item.main_byte[7]) begin
            run.colors[i] = (item.column[0] ^ i[0]) ? COLOR_BLUE : COLOR_ORANGE;
          end else begin
            run.colors[i] = (item.column[0] ^ i[0]) ? COLOR_PURPLE : COLOR_GREEN;
          end
        end
        state_next.prev_dot = item.main_byte[CellsPerByte-1];
      end
      MODE_DHIRES: begin
        run.width = CELL_W_WIDE;
        run.count = four_cells ? 3'd4 : 3'd3;
        for (int k = 0; k < 4; k++) begin
          run.colors[k] = dhires_color(q[4*k +: 4]);
        end
        if (four_cells) begin
          state_next.queue     = {2'b00, q[16]};
          state_next.queue_cnt = 2'(total - 5'd16);
        end else begin
          state_next.queue     = q[14:12];
          state_next.queue_cnt = 2'(total - 5'd12);
        end
      end
      default: begin
        run.count = 3'd0;   // unused mode: no cells
      end
    endcase
  end

endmodule

// ===== design/graphics_byte_pixel_decoder_top.sv =====
// ----------------------------------------------------------------------------
// graphics_byte_pixel_decoder_top
// Turns each fetched graphics column into a run of colored pixel cells.
// ----------------------------------------------------------------------------
//  channel  | signals                           | direction
//  ---------+-----------------------------------+----------
//  in       | in_valid, in_ready, in_data       | input item: one column
//  out      | out_valid, out_ready, out_data    | result item: one pixel cell
//  cfg      | cfg_valid, cfg_ready, cfg_data    | graphics_mode write
//
//  A column item is registered, decoded in one pass into a cell buffer, and the
//  cells leave through an output register at one per cycle unless the output
//  stalls: 7 cells per item in low-res and high-res, 3 or 4 in double high-res,
//  none in the unused mode.
//  The next item waits in the input register while cells drain.
//  Reset is synchronous: mode goes to high-res, line state and valids clear.
//  Output stalls hold the output register and back up into the cell buffer.
// ----------------------------------------------------------------------------
module graphics_byte_pixel_decoder_top
  import gbpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  logic        [1:0] mode;
  logic              a_valid;
  in_item_t          a_item;
  line_state_t       lstate;
  line_state_t       lstate_next;
  cell_run_t         dec_run;
  logic [CellsPerByte-1:0][23:0] b_colors;
  logic        [2:0] b_cnt;
  logic        [2:0] b_idx;
  logic        [2:0] b_width;
  logic        [2:0] b_idx_inc;
  logic              b_has;
  logic              b_free;
  logic              out_load;
  logic              a_take;

  assign cfg_ready = 1'b1;

  gbpd_decode u_decode (
    .item       (a_item),
    .mode       (mode),
    .state      (lstate),
    .run        (dec_run),
    .state_next (lstate_next)
  );

  assign b_idx_inc = b_idx + 3'd1;
  assign b_has     = (b_idx != b_cnt);
  assign out_load  = b_has && (!out_valid || out_ready);
  assign b_free    = !b_has || (out_load && (b_idx_inc == b_cnt));
  assign a_take    = a_valid && b_free;
  assign in_ready  = !a_valid || a_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
    end else if (cfg_valid) begin
      mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_valid <= 1'b1;
    end else if (a_take) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lstate <= '0;
    end else if (a_take) begin
      lstate <= lstate_next;
    end
  end

  // cell buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      b_cnt <= 3'd0;
      b_idx <= 3'd0;
    end else if (a_take) begin
      b_cnt <= dec_run.count;
      b_idx <= 3'd0;
    end else if (out_load) begin
      b_idx <= b_idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      b_colors <= dec_run.colors;
      b_width  <= dec_run.width;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.color_rgb      <= b_colors[b_idx];
      out_data.cell_width     <= b_width;
      out_data.last_of_column <= (b_idx_inc == b_cnt);
    end
  end

  // buffer index never runs past the run length
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    b_idx <= b_cnt)
    else $error("cell index past run length");

  // an item waiting in the input register stays until the buffer takes it
  a_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_take |=> a_valid)
    else $error("input item lost");

  // double high-res always yields three or four cells
  a_dhr_cnt: assert property (@(posedge clk) disable iff (rst)
    a_take && (mode == MODE_DHIRES) |-> (dec_run.count == 3'd3) || (dec_run.count == 3'd4))
    else $error("bad double high-res cell count");

  // a cell is never sent while the buffer is empty
  a_load_src: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (b_cnt != 3'd0))
    else $error("cell sent from empty buffer");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the graphics byte pixel decoder. Column items are
// sent in low-res, high-res, double high-res and the unused mode. A local
// decoder keeps its own line state and builds the expected pixel cells. Each
// cell that leaves the block is compared field by field with the oldest
// expected one. Both handshakes idle at random, with some stretches at full
// rate.
// ----------------------------------------------------------------------------
module tb_top;
  import gbpd_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int InBits = $bits(in_item_t);

  // palettes, entry 0 in the low bits
  localparam logic [16*24-1:0] LORES_PAL = {
    24'hFFFFFF, 24'h44FF99, 24'hFFFF00, 24'h22FF00, 24'hFF99FF, 24'hAAAAAA,
    24'hFF6600, 24'h885500, 24'hAAAAFF, 24'h0EA1FF, 24'h808080, 24'h119D00,
    24'hDB42FF, 24'h2B2BE3, 24'h9D09AA, 24'h000000};
  localparam logic [16*24-1:0] DHIRES_PAL = {
    24'hFFFFFF, 24'h44FF99, 24'hFFFF00, 24'h00DD00, 24'hFF99AA, 24'hAAAAAA,
    24'hFF6600, 24'h885500, 24'h66AAFF, 24'h2222FF, 24'h555555, 24'h007722,
    24'hDD22DD, 24'h000099, 24'hDD0033, 24'h000000};

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b1;
  out_item_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = '0;

  // local decoder state
  logic [1:0]  disp_mode = MODE_RESET;
  logic        prev_dot = 1'b0;
  logic [16:0] dq_bits = '0;
  logic [4:0]  dq_cnt = '0;

  out_item_t cells_due[$];
  int        fail_count = 0;
  bit        no_idle = 1'b0;

  // random line walk
  int         col_cursor = 0;
  logic [7:0] line_cursor = '0;
  logic [7:0] upcoming_main = '0;

  graphics_byte_pixel_decoder_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic in_item_t make_item(input logic [7:0] main_b, input logic [7:0] aux_b,
                                         input logic nlb, input logic [5:0] col,
                                         input logic [7:0] ln);
    in_item_t it;
    it.main_byte    = main_b;
    it.aux_byte     = aux_b;
    it.next_low_bit = nlb;
    it.column       = col;
    it.line         = ln;
    return it;
  endfunction

  function automatic void owe_cell(input logic [23:0] rgb, input logic [2:0] width,
                                   input logic last);
    out_item_t c;
    c.color_rgb      = rgb;
    c.cell_width     = width;
    c.last_of_column = last;
    cells_due.push_back(c);
  endfunction

  function automatic void decode_column(input in_item_t it);
    logic [3:0]  nib;
    logic        dot;
    logic        nbr;
    logic [23:0] rgb;
    logic [13:0] fresh_bits;
    logic [31:0] q;
    int          cnt;
    int          i;
    if (it.column == 6'd0) begin
      prev_dot = 1'b0;
      dq_bits  = '0;
      dq_cnt   = '0;
    end
    case (disp_mode)
      MODE_LORES: begin
        nib = (it.line[2:0] < 3'd4) ? it.main_byte[3:0] : it.main_byte[7:4];
        for (i = 0; i < CellsPerByte; i++)
          owe_cell(LORES_PAL[nib*24 +: 24], CELL_W_NARROW, i == CellsPerByte - 1);
      end
      MODE_HIRES: begin
        for (i = 0; i < CellsPerByte; i++) begin
          dot = it.main_byte[i];
          nbr = (i < CellsPerByte - 1) ? it.main_byte[i+1] : it.next_low_bit;
          rgb = COLOR_BLACK;
          if (dot) begin
            if (prev_dot || nbr)
              rgb = COLOR_WHITE;
            else if (it.main_byte[7])
              rgb = ((it.column + i) & 1) ? COLOR_BLUE : COLOR_ORANGE;
            else
              rgb = ((it.column + i) & 1) ? COLOR_PURPLE : COLOR_GREEN;
          end
          owe_cell(rgb, CELL_W_NARROW, i == CellsPerByte - 1);
          prev_dot = dot;
        end
      end
      MODE_DHIRES: begin
        fresh_bits = {it.main_byte[6:0], it.aux_byte[6:0]};
        q   = 32'(dq_bits[2:0]) | (32'(fresh_bits) << dq_cnt[1:0]);
        cnt = int'(dq_cnt[1:0]) + 14;
        while (cnt >= 4) begin
          owe_cell(DHIRES_PAL[q[3:0]*24 +: 24], CELL_W_WIDE, cnt < 8);
          q   = q >> 4;
          cnt = cnt - 4;
        end
        dq_bits = q[16:0];
        dq_cnt  = 5'(cnt);
      end
      default: ;  // unused mode: no cells, line state kept
    endcase
  endfunction

  function automatic void check_cell(input out_item_t got);
    out_item_t want;
    if (cells_due.size() == 0) begin
      $error("unexpected cell: color_rgb %h cell_width %0d last_of_column %0d",
             got.color_rgb, got.cell_width, got.last_of_column);
      fail_count++;
      return;
    end
    want = cells_due.pop_front();
    if (got.color_rgb !== want.color_rgb) begin
      $error("color_rgb: expected %h, got %h", want.color_rgb, got.color_rgb);
      fail_count++;
    end
    if (got.cell_width !== want.cell_width) begin
      $error("cell_width: expected %0d, got %0d", want.cell_width, got.cell_width);
      fail_count++;
    end
    if (got.last_of_column !== want.last_of_column) begin
      $error("last_of_column: expected %0d, got %0d", want.last_of_column,
             got.last_of_column);
      fail_count++;
    end
  endfunction

  // result side: check every accepted cell, then maybe stall
  initial begin : cell_checker
    int stall;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        check_cell(out_data);
        stall = draw_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_column(input in_item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_column(it);
  endtask

  // wait until all cells are back, then let any unused-mode item finish
  task automatic settle();
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] mode);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    disp_mode = mode;
  endtask

  // high-res straight out of reset: artifact colors, neighbors, line start
  task automatic test_hires_after_reset();
    send_column(make_item(8'h00, 8'h00, 1'b0, 6'd0, 8'd0));
    send_column(make_item(8'h01, 8'hFF, 1'b0, 6'd0, 8'd1));   // lone dot, even x
    send_column(make_item(8'h01, 8'h00, 1'b0, 6'd1, 8'd1));   // lone dot, odd x
    send_column(make_item(8'h82, 8'h00, 1'b0, 6'd2, 8'd1));   // palette bit set
    send_column(make_item(8'h40, 8'h00, 1'b1, 6'd3, 8'd1));   // neighbor in next column
    send_column(make_item(8'h01, 8'h00, 1'b0, 6'd4, 8'd1));   // neighbor in last column
    send_column(make_item(8'h7F, 8'h00, 1'b1, 6'd5, 8'd1));
    send_column(make_item(8'h01, 8'h00, 1'b0, 6'd0, 8'd2));   // new line drops the dot
    send_column(make_item(8'hD5, 8'h80, 1'b1, 6'd63, 8'd255));
    send_column(make_item(8'hAA, 8'h7F, 1'b0, 6'd45, 8'd128));
  endtask

  task automatic test_lores_nibbles();
    set_mode(MODE_LORES);
    no_idle = 1'b1;
    send_column(make_item(8'h5A, 8'h00, 1'b0, 6'd0, 8'd0));
    send_column(make_item(8'hF0, 8'hFF, 1'b1, 6'd1, 8'd3));
    send_column(make_item(8'hF0, 8'h00, 1'b0, 6'd2, 8'd4));
    send_column(make_item(8'h3C, 8'h00, 1'b1, 6'd3, 8'd7));
    send_column(make_item(8'hC1, 8'hAA, 1'b0, 6'd63, 8'd255));
    send_column(make_item(8'h96, 8'h55, 1'b0, 6'd39, 8'd191));
    no_idle = 1'b0;
  endtask

  // each piece of line state survives the other modes within a line
  task automatic test_mode_switch_in_line();
    set_mode(MODE_DHIRES);
    send_column(make_item(8'h80, 8'hFF, 1'b0, 6'd0, 8'd10));
    send_column(make_item(8'h7F, 8'h00, 1'b1, 6'd1, 8'd10));
    send_column(make_item(8'hAA, 8'h55, 1'b0, 6'd2, 8'd10));   // leaves two bits queued
    set_mode(MODE_HIRES);
    send_column(make_item(8'h40, 8'h00, 1'b0, 6'd3, 8'd10));
    set_mode(MODE_UNUSED);
    send_column(make_item(8'hFF, 8'hFF, 1'b1, 6'd4, 8'd10));
    set_mode(MODE_DHIRES);
    send_column(make_item(8'hFF, 8'h80, 1'b1, 6'd5, 8'd10));
    set_mode(MODE_HIRES);
    send_column(make_item(8'h01, 8'h00, 1'b0, 6'd6, 8'd10));
    set_mode(MODE_UNUSED);
    send_column(make_item(8'h00, 8'h00, 1'b0, 6'd0, 8'd11));   // clears even when unused
    set_mode(MODE_HIRES);
    send_column(make_item(8'h01, 8'h00, 1'b0, 6'd1, 8'd11));
  endtask

  // mostly well-formed lines with random bytes, some stray columns
  task automatic test_random_lines();
    int       counted;
    int       quota;
    int       pick;
    logic [1:0] mode;
    in_item_t it;
    counted = 0;
    while (counted < 170) begin
      pick = $urandom_range(0, 9);
      mode = (pick < 3) ? MODE_LORES : (pick < 6) ? MODE_HIRES :
             (pick < 9) ? MODE_DHIRES : MODE_UNUSED;
      set_mode(mode);
      no_idle = ($urandom_range(0, 3) == 0);
      quota = (mode == MODE_UNUSED) ? 6 : $urandom_range(20, 45);
      repeat (quota) begin
        if ($urandom_range(0, 9) == 0) begin
          it = InBits'($urandom);
        end else begin
          it.main_byte = upcoming_main;
          upcoming_main = ($urandom_range(0, 2) == 0) ? 8'($urandom & $urandom & $urandom)
                                                      : 8'($urandom);
          it.aux_byte     = 8'($urandom);
          it.column       = 6'(col_cursor);
          it.line         = line_cursor;
          it.next_low_bit = (col_cursor == 39) ? 1'b0 : upcoming_main[0];
          col_cursor++;
          if (col_cursor == 40 || $urandom_range(0, 24) == 0) begin
            col_cursor  = 0;
            line_cursor = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(0, 191));
          end
        end
        send_column(it);
      end
      counted += quota;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_hires_after_reset();
    test_lores_nibbles();
    test_mode_switch_in_line();
    test_random_lines();
    settle();
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== graphics_byte_pixel_decoder_top.f =====
design/gbpd_pkg.sv
design/gbpd_decode.sv
design/graphics_byte_pixel_decoder_top.sv
test/tb_top.sv
